// ===== rtl/core/ocr_text_byte_cleaner_defines.svh =====
// Assertion macros shared by the cleaner's checker.
`ifndef OCR_TEXT_BYTE_CLEANER_DEFINES_SVH
`define OCR_TEXT_BYTE_CLEANER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OTBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define OTBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/otbc_pkg.sv =====
// Types, byte codes and sizes for the OCR text byte cleaner.
`default_nettype none
package otbc_pkg;

  // One text request: a byte or the end of the text.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } otbc_req_t;

  // One cleaned result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_last;
  } otbc_res_t;

  localparam int MAX_RESULTS   = 4;
  localparam int QUEUE_DEPTH   = 8;
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

  // Results produced by one request, plus the newline hold-back state.
  typedef struct packed {
    logic                          held_nl;
    logic                          prev_nl;
    logic [NRES_W-1:0]             nres;
    otbc_res_t [MAX_RESULTS-1:0]   res;
  } otbc_acc_t;

  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LIG_LEAD   = 8'hEF;
  localparam logic [7:0] LIG_MID    = 8'hAC;
  localparam logic [7:0] LIG_FI     = 8'h81;
  localparam logic [7:0] LIG_FL     = 8'h82;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_L     = 8'h6C;

endpackage
`default_nettype wire

// ===== rtl/core/ocr_text_byte_cleaner.sv =====
// Top level of the OCR text byte cleaner: pattern window, newline hold and result queue.
`default_nettype none
// The first result of a request shows on clean_* in the cycle after acceptance when the
//   queue is empty; results queued ahead of it, and stalls on clean_stall, hold it back.
// Throughput: one request per cycle while text_stall is low; a request makes zero to four
//   results, drained one per cycle while clean_stall is low from a QUEUE_DEPTH-entry result
//   queue, and text_stall rises while the queue cannot take four more results.
// Reset (rst, synchronous, active high) empties the queue and restarts leading-space skip;
//   pending window bytes are not cleared, only their count.
module ocr_text_byte_cleaner #(
  parameter int QUEUE_DEPTH = otbc_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 text_valid,
  output logic                text_stall,
  input  otbc_pkg::otbc_req_t text_data,
  output logic                clean_valid,
  input  wire                 clean_stall,
  output otbc_pkg::otbc_res_t clean_data
);
  import otbc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Cleaning state.
  logic       lead_space, lead_space_next;
  logic [7:0] pend0, pend0_next;
  logic [7:0] pend1, pend1_next;
  logic [1:0] pend_cnt, pend_cnt_next;
  logic       held_nl, held_nl_next;
  logic       prev_nl, prev_nl_next;

  // Result queue: entry 0 is the head shown on clean_data.
  otbc_res_t  queue [QUEUE_DEPTH];
  otbc_res_t  queue_next [QUEUE_DEPTH];
  logic [CNT_W-1:0] count, count_next;

  logic       take;   // request accepted this cycle
  logic       pop;    // head result taken this cycle
  otbc_acc_t  acc;    // results of the accepted request

  // Append one result to the per-request list.
  function automatic otbc_acc_t put_res(otbc_acc_t a, logic [7:0] b, logic has, logic last);
    otbc_acc_t r;
    r = a;
    if (r.nres < NRES_W'(MAX_RESULTS)) begin
      r.res[r.nres[1:0]] = '{out_byte: b, has_byte: has, is_last: last};
      r.nres = r.nres + NRES_W'(1);
    end
    return r;
  endfunction

  // Newline hold-back stage: a newline waits for the next byte or the end.
  function automatic otbc_acc_t send_byte(otbc_acc_t a, logic [7:0] b);
    otbc_acc_t r;
    r = a;
    if (r.held_nl) begin
      r = put_res(r, NL_BYTE, 1'b1, 1'b0);
      r.prev_nl = 1'b1;
      r.held_nl = 1'b0;
    end
    if (b == NL_BYTE) begin
      r.held_nl = 1'b1;
    end else begin
      r = put_res(r, b, 1'b1, 1'b0);
      r.prev_nl = 1'b0;
    end
    return r;
  endfunction

  assign text_stall  = (count > CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign take        = text_valid && !text_stall;
  assign clean_valid = (count != '0);
  assign clean_data  = queue[0];
  assign pop         = clean_valid && !clean_stall;

  // One pass over the request: leading-space skip, three-byte window, hold-back.
  always_comb begin
    logic [7:0] b;
    b               = text_data.data_byte;
    acc             = '0;
    acc.held_nl     = held_nl;
    acc.prev_nl     = prev_nl;
    lead_space_next = lead_space;
    pend0_next      = pend0;
    pend1_next      = pend1;
    pend_cnt_next   = pend_cnt;
    if (take) begin
      if (text_data.end_mark) begin
        // Flush pending bytes, then a held newline unless it would double one.
        if (pend_cnt != 2'd0) acc = send_byte(acc, pend0);
        if (pend_cnt == 2'd2) acc = send_byte(acc, pend1);
        if (acc.held_nl && !acc.prev_nl) acc = put_res(acc, NL_BYTE, 1'b1, 1'b0);
        if (acc.nres == '0) begin
          acc = put_res(acc, 8'h00, 1'b0, 1'b1);   // empty text: end marker alone
        end else begin
          acc.res[2'(acc.nres - NRES_W'(1))].is_last = 1'b1;
        end
        acc.held_nl     = 1'b0;
        acc.prev_nl     = 1'b0;
        lead_space_next = 1'b1;
        pend_cnt_next   = 2'd0;
      end else if (!(lead_space && (b inside {[TAB_BYTE:CR_BYTE], SPACE_BYTE}))) begin
        lead_space_next = 1'b0;
        if (pend_cnt != 2'd2) begin
          if (pend_cnt[0]) pend1_next = b;
          else             pend0_next = b;
          pend_cnt_next = pend_cnt + 2'd1;
        end else if (pend0 == LIG_LEAD && pend1 == LIG_MID && b == LIG_FI) begin
          acc = send_byte(acc, CHAR_F);
          acc = send_byte(acc, CHAR_I);
          pend_cnt_next = 2'd0;
        end else if (pend0 == LIG_LEAD && pend1 == LIG_MID && b == LIG_FL) begin
          acc = send_byte(acc, CHAR_F);
          acc = send_byte(acc, CHAR_L);
          pend_cnt_next = 2'd0;
        end else if (pend0 == NL_BYTE && pend1 == SPACE_BYTE && b == NL_BYTE) begin
          pend_cnt_next = 2'd0;                    // newline, space, newline dropped
        end else begin
          acc = send_byte(acc, pend0);
          pend0_next = pend1;
          pend1_next = b;
        end
      end
    end
    held_nl_next = acc.held_nl;
    prev_nl_next = acc.prev_nl;
  end

  // Queue update: shift out the head on pop, append new results behind the rest.
  always_comb begin
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] off;
    base = count - CNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      idx = CNT_W'(i);
      off = idx - base;
      if (pop && (i + 1 < QUEUE_DEPTH)) queue_next[i] = queue[(i + 1) % QUEUE_DEPTH];
      else                              queue_next[i] = queue[i];
      if (idx >= base && off < CNT_W'(acc.nres)) queue_next[i] = acc.res[off[1:0]];
    end
    count_next = base + CNT_W'(acc.nres);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_space <= 1'b1;
      pend_cnt   <= 2'd0;
      held_nl    <= 1'b0;
      prev_nl    <= 1'b0;
      count      <= '0;
    end else begin
      lead_space <= lead_space_next;
      pend_cnt   <= pend_cnt_next;
      held_nl    <= held_nl_next;
      prev_nl    <= prev_nl_next;
      count      <= count_next;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    pend0 <= pend0_next;
    pend1 <= pend1_next;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/otbc_checker.sv =====
// Port-level assertions for the OCR text byte cleaner, bound to the top level.
`default_nettype none
`include "ocr_text_byte_cleaner_defines.svh"
module otbc_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 text_valid,
  input wire                 text_stall,
  input otbc_pkg::otbc_req_t text_data,
  input wire                 clean_valid,
  input wire                 clean_stall,
  input otbc_pkg::otbc_res_t clean_data
);
  import otbc_pkg::*;

  logic text_seen;
  assign text_seen = text_valid && !text_stall && (text_data.end_mark || !text_data.end_mark);

  `OTBC_ASSERT_NEXT(a_res_hold, clk, rst, clean_valid && clean_stall, clean_valid && $stable(clean_data), "stalled result changed")
  `OTBC_ASSERT_NOW(a_marker_last, clk, rst, clean_valid && !clean_data.has_byte, clean_data.is_last, "end marker not flagged last")
  `OTBC_ASSERT_NOW(a_marker_zero, clk, rst, clean_valid && !clean_data.has_byte, clean_data.out_byte == 8'h00, "end marker carries a byte")
  `OTBC_ASSERT_NEXT(a_no_spurious, clk, rst, !clean_valid && !text_seen, !clean_valid, "result without request")

endmodule

bind ocr_text_byte_cleaner otbc_checker u_otbc_checker (.*);
`default_nettype wire
